// ===== hdl/lbfr_pkg.sv =====
// shared types and constants for the lru buffer frame replacer
package lbfr_pkg;

    localparam int OP_W     = 2;
    localparam int PAGE_W   = 10;
    localparam int HANDLE_W = 32;
    localparam int CFG_W    = 5;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index carried in the word address bit of paddr
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_MARK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_TOUCH,
        ACT_MARK,
        ACT_FILL,
        ACT_EVICT
    } t_act;

    typedef struct packed {
        logic load;
        logic look;
        logic srch;
        logic vread;
        logic commit;
        t_act act;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic hit;
        logic refused;
        logic full;
        logic srch_last;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] found_handle;
        logic                accepted;
        logic                evicted_valid;
        logic [PAGE_W-1:0]   evicted_page;
        logic [HANDLE_W-1:0] evicted_handle;
    } t_result;

endpackage

// ===== hdl/lbfr_if.sv =====
// request and response channel interfaces
interface lbfr_req_if;
    import lbfr_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [PAGE_W-1:0]   page_number;
    logic [HANDLE_W-1:0] page_handle;
    logic                pinned;
    logic                dirty;

    modport source (output valid, op, page_number, page_handle, pinned, dirty, input ready);
    modport sink   (input valid, op, page_number, page_handle, pinned, dirty, output ready);
endinterface

interface lbfr_rsp_if;
    import lbfr_pkg::*;
    logic                valid;
    logic                ready;
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                accepted;
    logic                evicted_valid;
    logic [PAGE_W-1:0]   evicted_page;
    logic [HANDLE_W-1:0] evicted_handle;

    modport source (output valid, hit, found_handle, accepted, evicted_valid, evicted_page,
                    evicted_handle, input ready);
    modport sink   (input valid, hit, found_handle, accepted, evicted_valid, evicted_page,
                    evicted_handle, output ready);
endinterface

// ===== hdl/lbfr_ram.sv =====
// generic single write port ram with registered read
module lbfr_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lbfr_ctrl.sv =====
// sequencing state machine: lookup, victim search, victim read, commit
module lbfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lbfr_pkg::t_sts i_sts,
    output lbfr_pkg::t_cmd o_cmd
);
    import lbfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SRCH,
        S_VREAD,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    t_act   r_act, n_act;
    logic   ready;

    assign ready = (r_state == S_IDLE) || ((r_state == S_COMMIT) && i_sts.out_free);

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_COMMIT;
                n_act   = ACT_NONE;
                case (i_sts.op)
                    OP_GET: begin
                        if (i_sts.hit) begin
                            n_act = ACT_TOUCH;
                        end
                    end
                    OP_MARK: begin
                        if (i_sts.hit) begin
                            n_act = ACT_MARK;
                        end
                    end
                    OP_PUT: begin
                        if (!i_sts.refused && !i_sts.hit) begin
                            if (i_sts.full) begin
                                n_act   = ACT_EVICT;
                                n_state = S_SRCH;
                            end else begin
                                n_act = ACT_FILL;
                            end
                        end
                    end
                    default: n_act = ACT_NONE;
                endcase
            end
            S_SRCH: begin
                if (i_sts.srch_last) begin
                    n_state = S_VREAD;
                end
            end
            S_VREAD: n_state = S_COMMIT;
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_in_valid ? S_LOOK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_NONE;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

    always_comb begin
        o_cmd.load   = i_in_valid && ready;
        o_cmd.look   = (r_state == S_LOOK);
        o_cmd.srch   = (r_state == S_SRCH);
        o_cmd.vread  = (r_state == S_VREAD);
        o_cmd.commit = (r_state == S_COMMIT) && i_sts.out_free;
        o_cmd.act    = r_act;
    end

    assign o_in_ready = ready;
endmodule

// ===== hdl/lbfr_dpath.sv =====
// frame table, page match, age search, handle ram and result register
module lbfr_dpath #(
    parameter int FRAMES = 16,
    parameter int PAGES  = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lbfr_pkg::t_cmd                  i_cmd,
    output lbfr_pkg::t_sts                  o_sts,
    input  logic [lbfr_pkg::OP_W-1:0]       i_op,
    input  logic [lbfr_pkg::PAGE_W-1:0]     i_page_number,
    input  logic [lbfr_pkg::HANDLE_W-1:0]   i_page_handle,
    input  logic                            i_pinned,
    input  logic                            i_dirty,
    input  logic [lbfr_pkg::CFG_W-1:0]      i_frames_in_use,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output lbfr_pkg::t_result               o_res
);
    import lbfr_pkg::*;

    localparam int IDX_W  = $clog2(FRAMES);
    localparam int AGE_W  = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int NSTEP  = (AGE_W + 1) / 2;
    localparam int SW     = 2 * NSTEP;
    localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int PCW    = ($clog2(PAGES + 1) > PAGE_W) ? $clog2(PAGES + 1) : PAGE_W;
    localparam int RAM_W  = PAGE_W + HANDLE_W;

    function automatic logic [IDX_W-1:0] f_enc(input logic [FRAMES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (v[i]) begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

    // captured request
    t_op                 r_op;
    logic [PAGE_W-1:0]   r_pg;
    logic [HANDLE_W-1:0] r_hd;
    logic                r_ipin;
    logic                r_idirty;

    // frame table
    logic [FRAMES-1:0] r_valid, n_valid;
    logic [FRAMES-1:0] r_pin, n_pin;
    logic [FRAMES-1:0] r_dirty, n_dirty;
    logic [AGE_W-1:0]  r_age [FRAMES];
    logic [AGE_W-1:0]  n_age [FRAMES];
    logic [PAGE_W-1:0] r_page [FRAMES];
    logic [CNT_W-1:0]  r_res_cnt, n_res_cnt;
    logic [CNT_W-1:0]  r_pin_cnt, n_pin_cnt;

    // lookup and search
    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] r_match;
    logic              r_hit, r_refused;
    logic [FRAMES-1:0] r_cand, cand_hi, cand_mid, cand_lo, cand_nx;
    logic [STEP_W-1:0] r_step;
    logic              pg_ok, hit_c, refused_c, full_c;
    logic [LIM_W-1:0]  fiu_x, lim;

    // commit
    logic [FRAMES-1:0] sel, free_v, free_oh, wsel;
    logic [AGE_W-1:0]  sel_age;
    logic              have_victim, old_pin, out_free;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [RAM_W-1:0]  ram_rdata;
    t_result           res_c;
    t_result           r_res;
    logic              r_out_valid;

    // usable limit: zero acts as one, anything above the pool acts as the pool
    always_comb begin
        fiu_x = LIM_W'(i_frames_in_use);
        if (fiu_x == '0) begin
            lim = LIM_W'(1);
        end else if (fiu_x > LIM_W'(FRAMES)) begin
            lim = LIM_W'(FRAMES);
        end else begin
            lim = fiu_x;
        end
    end

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match[i] = r_valid[i] && (r_page[i] == r_pg);
        end
        pg_ok     = PCW'(r_pg) < PCW'(PAGES);
        hit_c     = (|match) && pg_ok && (r_op != OP_NONE);
        refused_c = (LIM_W'(r_pin_cnt) >= lim) || !pg_ok;
        full_c    = LIM_W'(r_res_cnt) >= lim;
    end

    // two age bits per search step, msb first; ages of valid frames are distinct
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            logic [SW-1:0] ae;
            ae         = SW'(r_age[i]) >> {r_step, 1'b0};
            cand_hi[i] = r_cand[i] && ae[1];
            cand_lo[i] = 1'b0;
        end
        cand_mid = (|cand_hi) ? cand_hi : r_cand;
        for (int i = 0; i < FRAMES; i++) begin
            logic [SW-1:0] ae;
            ae         = SW'(r_age[i]) >> {r_step, 1'b0};
            cand_lo[i] = cand_mid[i] && ae[0];
        end
        cand_nx = (|cand_lo) ? cand_lo : cand_mid;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_pg     <= i_page_number;
            r_hd     <= i_page_handle;
            r_ipin   <= i_pinned;
            r_idirty <= i_dirty;
        end
        if (i_cmd.look) begin
            r_match   <= match;
            r_hit     <= hit_c;
            r_refused <= refused_c;
            r_cand    <= r_valid & ~r_pin;
            r_step    <= STEP_W'(NSTEP - 1);
        end else if (i_cmd.srch) begin
            r_cand <= cand_nx;
            r_step <= r_step - STEP_W'(1);
        end
    end

    assign have_victim = |r_cand;
    assign sel         = (i_cmd.act == ACT_EVICT) ? r_cand : r_match;
    assign free_v      = ~r_valid;
    assign free_oh     = free_v & (~free_v + FRAMES'(1));
    assign old_pin     = |(r_match & r_pin);

    always_comb begin
        sel_age = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (sel[i]) begin
                sel_age = sel_age | r_age[i];
            end
        end
    end

    always_comb begin
        n_valid   = r_valid;
        n_pin     = r_pin;
        n_dirty   = r_dirty;
        n_res_cnt = r_res_cnt;
        n_pin_cnt = r_pin_cnt;
        wsel      = '0;
        for (int i = 0; i < FRAMES; i++) begin
            n_age[i] = r_age[i];
        end
        if (i_cmd.commit) begin
            case (i_cmd.act)
                ACT_TOUCH, ACT_EVICT: begin
                    if (i_cmd.act == ACT_TOUCH || have_victim) begin
                        // the hit frame, or the victim reused in place, becomes most recent
                        for (int i = 0; i < FRAMES; i++) begin
                            if (sel[i]) begin
                                n_age[i] = '0;
                            end else if (r_valid[i] && (r_age[i] < sel_age)) begin
                                n_age[i] = r_age[i] + AGE_W'(1);
                            end
                        end
                        if (i_cmd.act == ACT_EVICT) begin
                            n_pin   = r_pin & ~sel;
                            n_dirty = r_dirty & ~sel;
                            wsel    = sel;
                        end
                    end
                end
                ACT_FILL: begin
                    for (int i = 0; i < FRAMES; i++) begin
                        if (free_oh[i]) begin
                            n_age[i] = '0;
                        end else if (r_valid[i]) begin
                            n_age[i] = r_age[i] + AGE_W'(1);
                        end
                    end
                    n_valid   = r_valid | free_oh;
                    n_pin     = r_pin & ~free_oh;
                    n_dirty   = r_dirty & ~free_oh;
                    n_res_cnt = r_res_cnt + CNT_W'(1);
                    wsel      = free_oh;
                end
                ACT_MARK: begin
                    n_pin   = r_ipin ? (r_pin | r_match) : (r_pin & ~r_match);
                    n_dirty = r_idirty ? (r_dirty | r_match) : (r_dirty & ~r_match);
                    if (r_ipin && !old_pin) begin
                        n_pin_cnt = r_pin_cnt + CNT_W'(1);
                    end else if (!r_ipin && old_pin) begin
                        n_pin_cnt = r_pin_cnt - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_pin     <= '0;
            r_dirty   <= '0;
            r_res_cnt <= '0;
            r_pin_cnt <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_valid   <= n_valid;
            r_pin     <= n_pin;
            r_dirty   <= n_dirty;
            r_res_cnt <= n_res_cnt;
            r_pin_cnt <= n_pin_cnt;
            for (int i = 0; i < FRAMES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FRAMES; i++) begin
            if (wsel[i]) begin
                r_page[i] <= r_pg;
            end
        end
    end

    // page and handle of each frame, read for a get hit or for the victim
    assign ram_re    = i_cmd.look || i_cmd.vread;
    assign ram_raddr = i_cmd.look ? f_enc(match) : f_enc(r_cand);
    assign ram_we    = |wsel;
    assign ram_waddr = f_enc(wsel);

    lbfr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_pg, r_hd}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        res_c.hit           = r_hit;
        res_c.found_handle  = ((r_op == OP_GET) && r_hit) ? ram_rdata[HANDLE_W-1:0] : '0;
        res_c.accepted      = (r_op == OP_PUT) && !r_refused &&
                              !((i_cmd.act == ACT_EVICT) && !have_victim);
        res_c.evicted_valid = (i_cmd.act == ACT_EVICT) && (|(r_cand & r_dirty));
        res_c.evicted_page  = res_c.evicted_valid ? ram_rdata[RAM_W-1:HANDLE_W] : '0;
        res_c.evicted_handle = res_c.evicted_valid ? ram_rdata[HANDLE_W-1:0] : '0;
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res <= res_c;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.hit       = hit_c;
        o_sts.refused   = refused_c;
        o_sts.full      = full_c;
        o_sts.srch_last = (r_step == '0);
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
endmodule

// ===== hdl/lru_buffer_frame_replacer_unit.sv =====
// top level of the lru buffer frame replacer: apb register, controller and datapath
//
//  channel   dir  handshake        beat contents
//  i_req     in   valid / ready    op, page_number, page_handle, pinned, dirty
//  o_rsp     out  valid / ready    hit, found_handle, accepted, evicted_valid,
//                                  evicted_page, evicted_handle
//  apb       in   psel / penable   frames_in_use at word 0 (paddr[2] selects the word)
//
// get, mark and put without eviction: lookup then commit per beat, back to back
// put into a full pool: lookup, age search, victim read, commit; the age search resolves two
//   age bits per cycle, then the victim's page and handle are read from the ram
// reset: i_rst_n synchronous active low; frame marks, ages and counts clear at once,
//   no clearing pass, a request beat is taken the first cycle after reset
// stalls: the result sits in an output register; the next beat is taken while it
//   waits, and that beat's commit waits until the output register is free
module lru_buffer_frame_replacer_unit #(
    parameter int FRAMES = 16,
    parameter int PAGES  = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lbfr_req_if.sink                     i_req,
    lbfr_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbfr_pkg::APB_AW-1:0]  paddr,
    input  logic [lbfr_pkg::APB_DW-1:0]  pwdata,
    output logic [lbfr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import lbfr_pkg::*;

    t_cmd             ctl_cmd;
    t_sts             dp_sts;
    t_result          dp_res;
    logic             dp_out_valid;
    logic             in_ready;
    logic [CFG_W-1:0] r_frames_in_use;
    logic             cfg_wr;

    // configuration register; the user must write it only while the unit is idle, the block does not enforce this
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_FRAMES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_IN_USE_RESET;
        end else if (cfg_wr) begin
            r_frames_in_use <= pwdata[CFG_W-1:0];
        end
    end

    // unused word reads as zero
    assign prdata = (paddr[APB_AW-1] == REG_FRAMES_IN_USE) ? APB_DW'(r_frames_in_use) : '0;

    // sequencing: idle -> look -> (search -> victim read) -> commit
    lbfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctl_cmd)
    );

    // frame table, ages, handle ram and the result register
    lbfr_dpath #(
        .FRAMES (FRAMES),
        .PAGES  (PAGES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_sts           (dp_sts),
        .i_op            (i_req.op),
        .i_page_number   (i_req.page_number),
        .i_page_handle   (i_req.page_handle),
        .i_pinned        (i_req.pinned),
        .i_dirty         (i_req.dirty),
        .i_frames_in_use (r_frames_in_use),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (dp_out_valid),
        .o_res           (dp_res)
    );

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = dp_out_valid;
    assign o_rsp.hit            = dp_res.hit;
    assign o_rsp.found_handle   = dp_res.found_handle;
    assign o_rsp.accepted       = dp_res.accepted;
    assign o_rsp.evicted_valid  = dp_res.evicted_valid;
    assign o_rsp.evicted_page   = dp_res.evicted_page;
    assign o_rsp.evicted_handle = dp_res.evicted_handle;

    // at most one datapath phase at a time
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl_cmd.look, ctl_cmd.srch, ctl_cmd.vread, ctl_cmd.commit}))
        else $error("more than one datapath phase active");

    // a commit never overwrites a result that has not been taken
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.commit |-> dp_sts.out_free)
        else $error("commit while output register busy");

    // every commit shows a result in the next cycle
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.commit |=> o_rsp.valid)
        else $error("commit did not produce a result beat");

    // the victim search only starts right after a lookup
    a_srch_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(ctl_cmd.srch) |-> $past(ctl_cmd.look))
        else $error("victim search started without a lookup");

endmodule

// ===== tb/lru_buffer_frame_replacer_unit_test.sv =====
// self-checking testbench for the lru buffer frame replacer: predictor, scoreboard and drivers
module lru_buffer_frame_replacer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lbfr_pkg::*;

    localparam int POOL_FRAMES = 16;
    localparam int POOL_PAGES  = 1024;
    localparam int GAP_MAX     = 17;
    localparam int RANDOM_PHASES = 7;
    localparam int BEATS_PER_PHASE = 97;
    localparam int HOT_SET_SIZE = 20;
    // slowest legal run is well under 100 us, so this only trips on a hang
    localparam int RUN_LIMIT_NS = 1_000_000;

    // one request beat as the sender sees it
    typedef struct packed {
        t_op                 op;
        logic [PAGE_W-1:0]   page;
        logic [HANDLE_W-1:0] handle;
        logic                pinned;
        logic                dirty;
    } t_req_beat;

    // tracks the buffer pool and queues the result each request should produce
    class frame_pool_scoreboard;
        bit                  live[POOL_FRAMES];
        logic [PAGE_W-1:0]   page_of[POOL_FRAMES];
        logic [HANDLE_W-1:0] handle_of[POOL_FRAMES];
        bit                  pinned_of[POOL_FRAMES];
        bit                  dirty_of[POOL_FRAMES];
        int                  age_of[POOL_FRAMES];
        int                  resident;
        int                  pinned_total;
        logic [CFG_W-1:0]    frames_in_use;
        t_result             expected_q[$];
        int                  mismatches;

        function new();
            frames_in_use = FRAMES_IN_USE_RESET;
            resident      = 0;
            pinned_total  = 0;
            mismatches    = 0;
        endfunction

        // apply one request to the pool and return what the block should answer
        function t_result lru_outcome(t_req_beat b);
            t_result r;
            int f;
            int victim;
            int slot;
            int lim;
            int a;
            r      = '0;
            f      = -1;
            victim = -1;
            slot   = -1;
            for (int i = 0; i < POOL_FRAMES; i++) begin
                if (f < 0 && live[i] && page_of[i] == b.page && b.page < POOL_PAGES) f = i;
            end
            // zero behaves as one, anything past the frame count as the frame count
            if (frames_in_use == 0) lim = 1;
            else if (frames_in_use > POOL_FRAMES) lim = POOL_FRAMES;
            else lim = frames_in_use;

            r.hit = (f >= 0) && (b.op != OP_NONE);
            case (b.op)
                OP_GET: begin
                    if (f >= 0) begin
                        r.found_handle = handle_of[f];
                        a = age_of[f];
                        for (int i = 0; i < POOL_FRAMES; i++) begin
                            if (live[i] && age_of[i] < a) age_of[i]++;
                        end
                        age_of[f] = 0;
                    end
                end
                OP_PUT: begin
                    // the all-pinned refusal is checked before residency
                    if (pinned_total < lim && b.page < POOL_PAGES) begin
                        if (f >= 0) begin
                            r.accepted = 1'b1;
                        end else begin
                            if (resident >= lim) begin
                                for (int i = 0; i < POOL_FRAMES; i++) begin
                                    if (live[i] && !pinned_of[i] &&
                                        (victim < 0 || age_of[i] > age_of[victim])) victim = i;
                                end
                                if (victim >= 0) begin
                                    if (dirty_of[victim]) begin
                                        r.evicted_valid  = 1'b1;
                                        r.evicted_page   = page_of[victim];
                                        r.evicted_handle = handle_of[victim];
                                    end
                                    live[victim] = 1'b0;
                                    a = age_of[victim];
                                    for (int i = 0; i < POOL_FRAMES; i++) begin
                                        if (live[i] && age_of[i] > a) age_of[i]--;
                                    end
                                    resident--;
                                    slot = victim;
                                end
                            end else begin
                                for (int i = 0; i < POOL_FRAMES; i++) begin
                                    if (slot < 0 && !live[i]) slot = i;
                                end
                            end
                            if (slot >= 0) begin
                                for (int i = 0; i < POOL_FRAMES; i++) begin
                                    if (live[i]) age_of[i]++;
                                end
                                live[slot]      = 1'b1;
                                page_of[slot]   = b.page;
                                handle_of[slot] = b.handle;
                                pinned_of[slot] = 1'b0;
                                dirty_of[slot]  = 1'b0;
                                age_of[slot]    = 0;
                                resident++;
                                r.accepted = 1'b1;
                            end
                        end
                    end
                end
                OP_MARK: begin
                    if (f >= 0) begin
                        if (b.pinned && !pinned_of[f]) pinned_total++;
                        if (!b.pinned && pinned_of[f]) pinned_total--;
                        pinned_of[f] = b.pinned;
                        dirty_of[f]  = b.dirty;
                    end
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_request(t_req_beat b);
            expected_q.push_back(lru_outcome(b));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("found_handle", want.found_handle, got.found_handle);
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
            compare_field("evicted_page", want.evicted_page, got.evicted_page);
            compare_field("evicted_handle", want.evicted_handle, got.evicted_handle);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    lbfr_req_if req_bus ();
    lbfr_rsp_if rsp_bus ();

    frame_pool_scoreboard pool_sb = new();

    // idle ceilings per side; a zero ceiling gives a stretch with no idling
    int req_gap_max   = GAP_MAX;
    int rsp_stall_max = GAP_MAX;

    // working set of pages for the current phase so that gets and marks hit often
    logic [PAGE_W-1:0] hot_pages[$];

    lru_buffer_frame_replacer_unit #(
        .FRAMES (POOL_FRAMES),
        .PAGES  (POOL_PAGES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("[lru_buffer_frame_replacer_unit] ERROR");
        $finish;
    end

    // one request beat: optional idle gap, then hold valid until the block takes it
    task automatic send_request(input t_op op, input logic [PAGE_W-1:0] page,
                                input logic [HANDLE_W-1:0] handle, input logic pin,
                                input logic dirty);
        t_req_beat b;
        int gap;
        b   = '{op: op, page: page, handle: handle, pinned: pin, dirty: dirty};
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.op          <= b.op;
        req_bus.page_number <= b.page;
        req_bus.page_handle <= b.handle;
        req_bus.pinned      <= b.pinned;
        req_bus.dirty       <= b.dirty;
        do @(posedge i_clk); while (!req_bus.ready);
        // beat taken at this edge, so the pool state moves now
        pool_sb.note_request(b);
    endtask

    // setup then access; the caller drops psel so back to back transfers keep it high
    task automatic apb_transfer(input logic wr, input logic [APB_AW-1:0] addr,
                                input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    // drain the pool, write the limit, read it back
    task automatic change_frames_in_use(input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] rd;
        logic [APB_AW-1:0] addr;
        req_bus.valid <= 1'b0;
        addr = {REG_FRAMES_IN_USE, 2'b00};
        while (pool_sb.expected_q.size() != 0) @(posedge i_clk);
        // room for a beat still between lookup and commit
        repeat (8) @(posedge i_clk);
        apb_transfer(1'b1, addr, APB_DW'(value), rd);
        pool_sb.frames_in_use = value;
        apb_transfer(1'b0, addr, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        pool_sb.compare_field("frames_in_use readback", value, rd[CFG_W-1:0]);
    endtask

    // result side: random stall per beat, then check whatever arrives
    initial begin
        t_result got;
        int stall;
        rsp_bus.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = $urandom_range(0, rsp_stall_max);
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            got.hit            = rsp_bus.hit;
            got.found_handle   = rsp_bus.found_handle;
            got.accepted       = rsp_bus.accepted;
            got.evicted_valid  = rsp_bus.evicted_valid;
            got.evicted_page   = rsp_bus.evicted_page;
            got.evicted_handle = rsp_bus.evicted_handle;
            pool_sb.check_response(got);
        end
    end

    // main sequence
    initial begin
        t_op                 op;
        logic [PAGE_W-1:0]   page;
        int                  pick;
        logic [CFG_W-1:0]    limit_value;

        // every input known from time zero
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.op          <= OP_NONE;
        req_bus.page_number <= '0;
        req_bus.page_handle <= '0;
        req_bus.pinned      <= 1'b0;
        req_bus.dirty       <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit of 16, empty pool, field extremes
        send_request(OP_GET, 10'd0, 32'h0, 1'b0, 1'b0);               // miss on empty pool
        send_request(OP_PUT, 10'd0, 32'h0000_0000, 1'b0, 1'b0);
        send_request(OP_PUT, 10'h3ff, 32'hffff_ffff, 1'b1, 1'b1);
        send_request(OP_GET, 10'h3ff, 32'h0, 1'b0, 1'b0);             // hit, all-ones handle
        send_request(OP_GET, 10'd0, 32'h0, 1'b0, 1'b0);               // page 1023 now oldest
        send_request(OP_PUT, 10'h3ff, 32'h1234_5678, 1'b0, 1'b0);     // resident put, no change
        send_request(OP_MARK, 10'h3ff, 32'h0, 1'b1, 1'b1);
        send_request(OP_MARK, 10'h155, 32'h0, 1'b1, 1'b1);            // mark of absent page
        send_request(OP_NONE, 10'd0, 32'hdead_beef, 1'b1, 1'b1);      // no-op, zero result
        send_request(OP_MARK, 10'h3ff, 32'h0, 1'b0, 1'b1);            // unpin, stay dirty

        // pool of two: dirty eviction, all-pinned refusal, clean eviction
        change_frames_in_use(5'd2);
        send_request(OP_PUT, 10'h2aa, 32'ha5a5_a5a5, 1'b0, 1'b0);     // evicts dirty page 1023
        send_request(OP_MARK, 10'd0, 32'h0, 1'b1, 1'b0);
        send_request(OP_MARK, 10'h2aa, 32'h0, 1'b1, 1'b1);            // every frame pinned
        send_request(OP_PUT, 10'h3ff, 32'h0bad_0bad, 1'b0, 1'b0);     // refused
        send_request(OP_PUT, 10'h2aa, 32'h0, 1'b0, 1'b0);             // resident but refused
        send_request(OP_MARK, 10'd0, 32'h0, 1'b0, 1'b0);
        send_request(OP_PUT, 10'h111, 32'h1111_1111, 1'b0, 1'b0);     // clean eviction of page 0

        // zero acts as one while two pages stay resident
        change_frames_in_use(5'd0);
        send_request(OP_MARK, 10'h2aa, 32'h0, 1'b0, 1'b1);
        send_request(OP_PUT, 10'h222, 32'h5a5a_5a5a, 1'b0, 1'b0);     // one out, one in
        send_request(OP_GET, 10'h111, 32'h0, 1'b0, 1'b0);

        // above the frame count acts as the frame count
        change_frames_in_use(5'd31);
        send_request(OP_PUT, 10'h333, 32'h3333_3333, 1'b0, 1'b0);
        send_request(OP_GET, 10'h222, 32'h0, 1'b0, 1'b0);

        // random phases, each with its own limit, working set and idle pattern
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    limit_value = 5'd16;
                end
                1: begin
                    limit_value = 5'd1;
                end
                2: begin
                    limit_value = 5'd17 + 5'($urandom_range(0, 14));
                end
                3: begin
                    limit_value = 5'd0;
                end
                default: begin
                    limit_value = 5'($urandom_range(0, 31));
                end
            endcase
            change_frames_in_use(limit_value);
            req_gap_max   = (p % 3 == 0) ? 0 : GAP_MAX;
            rsp_stall_max = (p % 2 == 0) ? 0 : GAP_MAX;

            hot_pages.delete();
            for (int k = 0; k < HOT_SET_SIZE; k++) hot_pages.push_back(PAGE_W'($urandom));

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) op = OP_GET;
                else if (pick < 70) op = OP_PUT;
                else if (pick < 92) op = OP_MARK;
                else op = OP_NONE;
                // mostly the working set, sometimes a random page from the whole page range
                if ($urandom_range(0, 99) < 85)
                    page = hot_pages[$urandom_range(0, HOT_SET_SIZE - 1)];
                else
                    page = PAGE_W'($urandom);
                // pin rarely so the pool does not lock up for the whole phase
                send_request(op, page, $urandom, ($urandom_range(0, 3) == 0),
                             1'($urandom));
            end
        end

        req_bus.valid <= 1'b0;
        while (pool_sb.expected_q.size() != 0) @(posedge i_clk);
        // catch any stray beat after the last expected one
        repeat (20) @(posedge i_clk);

        if (pool_sb.mismatches == 0 && pool_sb.expected_q.size() == 0) begin
            $display("[lru_buffer_frame_replacer_unit] OK");
        end else begin
            $display("[lru_buffer_frame_replacer_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lbfr_pkg.sv
hdl/lbfr_if.sv
hdl/lbfr_ram.sv
hdl/lbfr_ctrl.sv
hdl/lbfr_dpath.sv
hdl/lru_buffer_frame_replacer_unit.sv
tb/lru_buffer_frame_replacer_unit_test.sv
